FILE: rtl/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// shared constants, types and fade arithmetic for the palette fade engine
// ----------------------------------------------------------------------------
package pfe_pkg;

  // palette size and walk length
  localparam int ENTRIES  = 64;
  localparam int MAX_WALK = 64;
  localparam int WALK     = (ENTRIES > MAX_WALK) ? MAX_WALK : ENTRIES;
  localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = (WALK > 1) ? $clog2(WALK) : 1;

  // field widths
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 6;
  localparam int COLOR_W = 16;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FADE_OUT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FADE_IN  = 2'd2;

  // packed rgb555 constants
  localparam logic [COLOR_W-1:0] GUARD_BITS = 16'b1000010000100000;
  localparam logic [COLOR_W-1:0] STEP_ONE   = 16'b0000100001000010;
  localparam logic [COLOR_W-1:0] CHAN_MASK  = 16'b0111101111011111;

  typedef struct packed {
    logic                saved_we;
    logic                cur_we;
    logic [ADDR_W-1:0]   waddr;
    logic [COLOR_W-1:0]  saved_wdata;
    logic [COLOR_W-1:0]  cur_wdata;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] saved;
    logic [COLOR_W-1:0] cur;
  } mem_rsp_t;

  // one step toward black
  function automatic logic [COLOR_W-1:0] fade_down(input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] n;
    logic [COLOR_W-1:0] v;
    n = (c | GUARD_BITS) - STEP_ONE;
    v = n & GUARD_BITS;
    v = v - (v >> 5);
    return n & v;
  endfunction

  // one step toward the saved color
  function automatic logic [COLOR_W-1:0] fade_up(input logic [COLOR_W-1:0] s,
                                                 input logic [COLOR_W-1:0] d);
    logic [COLOR_W-1:0] n;
    logic [COLOR_W-1:0] v;
    n = (s & CHAN_MASK) + STEP_ONE;
    v = ((d & CHAN_MASK) - n) & GUARD_BITS;
    v = v - (v >> 5);
    return (d & v) | (n & ~v);
  endfunction

endpackage

FILE: rtl/pfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pfe_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_walker
// command decode, read-modify-write sequencer and two-slot result buffer
// ----------------------------------------------------------------------------
module pfe_walker
  import pfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [COLOR_W-1:0] in_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [INDEX_W-1:0] out_index,
  output logic [COLOR_W-1:0] out_color,
  output logic              out_last,
  output mem_req_t          mem_req,
  input  mem_rsp_t          mem_rsp
);

  // sequencer state
  logic             active;
  logic             fade_in;
  logic [CNT_W-1:0] k;
  logic             inflight;
  logic [CNT_W-1:0] inf_idx;
  logic             inf_last;

  // result buffer
  logic [INDEX_W-1:0] slot_index [2];
  logic [COLOR_W-1:0] slot_color [2];
  logic               slot_last  [2];
  logic               rd_ptr;
  logic               wr_ptr;
  logic [1:0]         count;

  logic               accept;
  logic               is_step;
  logic               is_load;
  logic               pop;
  logic               push;
  logic               issue;
  logic               k_last;
  logic [1:0]         used;
  logic [COLOR_W-1:0] new_color;

  assign in_ready = !active && !inflight;
  assign accept   = in_valid && in_ready;
  assign is_step  = (in_mode == MODE_FADE_OUT) || (in_mode == MODE_FADE_IN);
  assign is_load  = (in_mode == MODE_LOAD) && (32'(in_index) < ENTRIES);

  assign out_valid = (count != 2'd0);
  assign out_index = slot_index[rd_ptr];
  assign out_color = slot_color[rd_ptr];
  assign out_last  = slot_last[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push      = inflight;

  // slots taken after this cycle's pop, counting the read in flight
  assign used   = count + {1'b0, inflight} - {1'b0, pop};
  assign issue  = active && (used < 2'd2);
  assign k_last = (k == CNT_W'(WALK - 1));

  assign new_color = fade_in ? fade_up(mem_rsp.cur, mem_rsp.saved)
                             : fade_down(mem_rsp.cur);

  always_comb begin
    mem_req.raddr       = ADDR_W'(k);
    mem_req.saved_we    = accept && is_load;
    mem_req.cur_we      = inflight || (accept && is_load);
    mem_req.waddr       = inflight ? ADDR_W'(inf_idx) : ADDR_W'(in_index);
    mem_req.saved_wdata = in_color;
    mem_req.cur_wdata   = inflight ? new_color : in_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      fade_in  <= 1'b0;
      k        <= '0;
      inflight <= 1'b0;
      rd_ptr   <= 1'b0;
      wr_ptr   <= 1'b0;
      count    <= 2'd0;
    end else begin
      if (accept && is_step) begin
        active  <= 1'b1;
        fade_in <= (in_mode == MODE_FADE_IN);
        k       <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
        if (k_last) begin
          active <= 1'b0;
        end
      end
      inflight <= issue;
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      inf_idx  <= k;
      inf_last <= k_last;
    end
    if (push) begin
      slot_index[wr_ptr] <= INDEX_W'(inf_idx);
      slot_color[wr_ptr] <= new_color;
      slot_last[wr_ptr]  <= inf_last;
    end
  end

endmodule

FILE: rtl/palette_fade_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_engine_top
// rgb555 palette fade engine with saved and current palette memories
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes one color into both the saved and the
// current palette together and returns nothing. A fade-out (mode 1) or
// fade-in (mode 2) transaction walks entries 0 to 63 and returns one result
// per entry with tlast on the final one; mode 3 is dropped. The walk reads
// one entry per cycle from the two palette memories while the result
// buffer has room; results leave through a two-slot buffer, so output
// stalls slow the walk but never lose data. The input is held off
// (tready low) while a step is being walked, and a new step reads entry 0
// well after the previous write-back of it.
// Entries must be loaded before a step reads them.
// ----------------------------------------------------------------------------
module palette_fade_engine_top
  import pfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // input transaction
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // mode[1:0], entry_index[7:2], load_color[23:8]
  // result transaction
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // out_index[5:0], out_color[21:6], zero[23:22]
  output logic             m_axis_tlast    // last
);

  mem_req_t           mem_req;
  mem_rsp_t           mem_rsp;
  logic [INDEX_W-1:0] out_index;
  logic [COLOR_W-1:0] out_color;

  // sequencer, fade datapath and result buffer
  pfe_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tdata[1:0]),
    .in_index  (s_axis_tdata[7:2]),
    .in_color  (s_axis_tdata[23:8]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (out_index),
    .out_color (out_color),
    .out_last  (m_axis_tlast),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  // saved palette, written by loads only
  pfe_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (COLOR_W)
  ) u_saved_ram (
    .clk   (clk),
    .we    (mem_req.saved_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.saved_wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rsp.saved)
  );

  // current palette, written by loads and by step write-back
  pfe_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (COLOR_W)
  ) u_cur_ram (
    .clk   (clk),
    .we    (mem_req.cur_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.cur_wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rsp.cur)
  );

  assign m_axis_tdata = {2'b00, out_color, out_index};

endmodule

FILE: rtl/pfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker
// port-level checks for the palette fade engine
// ----------------------------------------------------------------------------
module pfe_checker
  import pfe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // a step holds off the input while it walks
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tdata[1:0] == MODE_FADE_OUT || s_axis_tdata[1:0] == MODE_FADE_IN)
    |=> !s_axis_tready)
    else $error("input accepted right after a step");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // last flag only on the final entry
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == 6'(WALK - 1))
    else $error("last flag on wrong entry");

  // entries of a run come in order
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
    |=> !m_axis_tvalid || m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)
    else $error("result index out of order");

  // nothing pending after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind palette_fade_engine_top pfe_checker u_pfe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_palette_fade_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_fade_engine_top
// self-checking bench for the rgb555 palette fade engine
// ----------------------------------------------------------------------------
// Fills the whole palette first, so no step ever reads an unwritten entry.
// A short directed sequence follows, then a long-stall pressure check and
// four random phases that differ in input and output idling. Every accepted
// input transaction is run through a local palette model. Each fade step
// queues 64 expected colors, and every output transaction is checked
// against the oldest one.
// ----------------------------------------------------------------------------
module tb_palette_fade_engine_top;
  import pfe_pkg::*;

  // mode 3 has no name in the package; the engine drops it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int CLK_PERIOD      = 10;
  localparam int DRAIN_CYCLES    = 100;  // one full walk plus pipeline slack
  localparam int HOLD_OFF_CYCLES = 400;  // long enough to back the input up
  localparam int PHASE_ITEMS     = 92;

  // one expected output transaction
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } entry_result_t;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // mode[1:0], entry_index[7:2], load_color[23:8]
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // out_index[5:0], out_color[21:6], zero[23:22]
  logic             m_axis_tlast;   // last

  // local copy of both palettes
  logic [COLOR_W-1:0] saved_pal [ENTRIES];
  logic [COLOR_W-1:0] cur_pal   [ENTRIES];

  // colors still owed by the engine, oldest first
  entry_result_t faded_entries_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;

  int mismatches      = 0;
  int loads_accepted  = 0;
  int steps_accepted  = 0;
  int drops_accepted  = 0;
  int results_checked = 0;

  palette_fade_engine_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // color arithmetic, all of it mod 2^16
  // ---------------------------------------------------------------------------

  // one step toward black; a channel at zero borrows from its guard bit,
  // and the mask built from the surviving guards clears that channel
  function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] dec;
    logic [COLOR_W-1:0] keep;
    dec  = (c | GUARD_BITS) - STEP_ONE;
    keep = dec & GUARD_BITS;
    keep = keep - (keep >> 5);
    return dec & keep;
  endfunction

  // one step toward the saved color; channels that would overshoot
  // take the saved value instead
  function automatic logic [COLOR_W-1:0] brighten_color(input logic [COLOR_W-1:0] cur,
                                                        input logic [COLOR_W-1:0] goal);
    logic [COLOR_W-1:0] inc;
    logic [COLOR_W-1:0] sel;
    inc = (cur & CHAN_MASK) + STEP_ONE;
    sel = ((goal & CHAN_MASK) - inc) & GUARD_BITS;
    sel = sel - (sel >> 5);
    return (goal & sel) | (inc & ~sel);
  endfunction

  // update the local palettes for one accepted transaction and queue the
  // colors that a step walk will return
  task automatic apply_palette_item(input logic [MODE_W-1:0]  mode,
                                    input logic [INDEX_W-1:0] idx,
                                    input logic [COLOR_W-1:0] color);
    entry_result_t res;
    case (mode)
      MODE_LOAD: begin
        loads_accepted++;
        if (idx < ENTRIES) begin
          saved_pal[idx] = color;
          cur_pal[idx]   = color;
        end
      end
      MODE_FADE_OUT, MODE_FADE_IN: begin
        steps_accepted++;
        for (int k = 0; k < WALK; k++) begin
          if (mode == MODE_FADE_OUT)
            cur_pal[k] = dim_color(cur_pal[k]);
          else
            cur_pal[k] = brighten_color(cur_pal[k], saved_pal[k]);
          res.index = INDEX_W'(k);
          res.color = cur_pal[k];
          res.last  = (k == WALK - 1);
          faded_entries_q.push_back(res);
        end
      end
      default: begin
        drops_accepted++;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls plus an on-demand long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each output transaction with the oldest expected color
  always @(posedge clk) begin : check_results
    entry_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (faded_entries_q.size() == 0) begin
        $error("unexpected result: index %0d color %h last %0b",
               m_axis_tdata[INDEX_W-1:0], m_axis_tdata[INDEX_W +: COLOR_W], m_axis_tlast);
        mismatches++;
      end else begin
        want = faded_entries_q.pop_front();
        if (m_axis_tdata[INDEX_W-1:0] !== want.index) begin
          $error("out_index mismatch: expected %0d, actual %0d",
                 want.index, m_axis_tdata[INDEX_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[INDEX_W +: COLOR_W] !== want.color) begin
          $error("out_color mismatch at entry %0d: expected %h, actual %h",
                 want.index, want.color, m_axis_tdata[INDEX_W +: COLOR_W]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last mismatch at entry %0d: expected %0b, actual %0b",
                 want.index, want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one transaction, with random idle cycles in front of it, and
  // model it once it is accepted
  task automatic send_item(input logic [MODE_W-1:0]  mode,
                           input logic [INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {color, idx, mode};
    do @(posedge clk); while (!s_axis_tready);
    apply_palette_item(mode, idx, color);
  endtask

  // stop offering and wait for every owed color
  task automatic wait_palette_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (faded_entries_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // load every entry once; the first few carry extreme and guard-bit patterns
  task automatic test_palette_fill();
    logic [COLOR_W-1:0] corner [12];
    corner = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h001F, 16'h03E0,
               16'h7C00, 16'h5555, 16'hAAAA, STEP_ONE, GUARD_BITS, CHAN_MASK};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < ENTRIES; i++)
      send_item(MODE_LOAD, INDEX_W'(i), (i < 12) ? corner[i] : COLOR_W'($urandom));
    wait_palette_drained();
  endtask

  // fade-in at target, fades, dropped mode, extreme reloads
  task automatic test_directed_fades();
    send_item(MODE_FADE_IN, '0, '0);             // current equals saved
    send_item(MODE_FADE_OUT, '0, '0);
    send_item(MODE_FADE_OUT, '0, '0);
    send_item(MODE_FADE_OUT, '0, '0);
    send_item(MODE_UNUSED, '1, '1);              // dropped, all field bits high
    send_item(MODE_UNUSED, '0, '0);
    send_item(MODE_FADE_IN, '0, '0);
    send_item(MODE_LOAD, 6'd0, 16'hFFFF);
    send_item(MODE_LOAD, 6'd63, 16'h0000);
    send_item(MODE_LOAD, 6'd31, 16'h7FFF);
    send_item(MODE_LOAD, 6'd32, 16'h8000);
    send_item(MODE_FADE_OUT, '0, '0);            // black entry stays put
    send_item(MODE_FADE_IN, '0, '0);
    send_item(MODE_FADE_IN, '0, '0);
    send_item(MODE_FADE_IN, '0, '0);
    send_item(MODE_LOAD, 6'd1, 16'h0000);
    send_item(MODE_FADE_IN, '0, '0);
    send_item(MODE_FADE_OUT, '0, '0);
    wait_palette_drained();
  endtask

  // long output hold-off while the sender keeps offering; the result buffer
  // fills, the walk stalls and the input backs up
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = HOLD_OFF_CYCLES;
    send_item(MODE_FADE_OUT, '0, '0);
    send_item(MODE_LOAD, 6'($urandom), 16'($urandom));
    send_item(MODE_FADE_IN, '0, '0);
    send_item(MODE_LOAD, 6'($urandom), 16'($urandom));
    send_item(MODE_FADE_OUT, '0, '0);
    send_item(MODE_FADE_IN, '0, '0);
    wait_palette_drained();
  endtask

  // random fade scenes: bursts of reloads, runs of fade-out and fade-in
  // steps (now and then long enough to reach black), and dropped mode noise
  task automatic run_palette_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    int counted;
    int pick;
    int run;
    counted        = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (counted < n_items) begin
      pick = $urandom_range(9);
      if (pick <= 3) begin
        run = $urandom_range(1, 6);
        repeat (run) send_item(MODE_LOAD, 6'($urandom), 16'($urandom));
        counted += run;
      end else if (pick <= 8) begin
        run = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
        repeat (run) send_item((pick <= 6) ? MODE_FADE_OUT : MODE_FADE_IN,
                               6'($urandom), 16'($urandom));
        counted += run;
      end else begin
        send_item(MODE_UNUSED, 6'($urandom), 16'($urandom));
      end
    end
    wait_palette_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_palette_fill();
    test_directed_fades();
    test_output_backpressure();
    run_palette_traffic(PHASE_ITEMS, 0, 0);     // no idling
    run_palette_traffic(PHASE_ITEMS, 61, 0);    // sparse input
    run_palette_traffic(PHASE_ITEMS, 0, 61);    // heavy output stalls
    run_palette_traffic(PHASE_ITEMS, 9, 9);     // light idling on both sides

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faded_entries_q.size() != 0) begin
      $error("%0d expected results never arrived", faded_entries_q.size());
      mismatches++;
    end

    $display("covered %0d loads, %0d fade steps, %0d dropped transactions, %0d colors checked",
             loads_accepted, steps_accepted, drops_accepted, results_checked);
    $display("idling: none, input only, output only, both; plus one long output hold-off");
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // safety net
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pfe_pkg.sv
rtl/pfe_ram.sv
rtl/pfe_walker.sv
rtl/palette_fade_engine_top.sv
rtl/pfe_checker.sv
tb/tb_palette_fade_engine_top.sv
